>>> design/vanc_cdp_caption_extractor_defines.svh
// ----------------------------------------------------------------------------
// Caption extractor assertion macros
// Shared property macros for the caption distribution packet extractor.
// ----------------------------------------------------------------------------
`ifndef VANC_CDP_CAPTION_EXTRACTOR_DEFINES_SVH
`define VANC_CDP_CAPTION_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VCCE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/vcce_pkg.sv
// ----------------------------------------------------------------------------
// Caption extractor package
// Types and constants shared by the caption distribution packet extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vcce_pkg;

	localparam logic [9:0] FLAG_ONE_WORD = 10'h3FF;
	localparam logic [9:0] FLAG_ZERO_WORD = 10'h000;
	localparam logic [9:0] DID_RESET = 10'h161;
	localparam logic [9:0] SDID_RESET = 10'h101;
	localparam logic [1:0] WANTED_RESET = 2'd0;

	typedef enum logic [1:0] {
		CFG_DID    = 2'd0,
		CFG_SDID   = 2'd1,
		CFG_WANTED = 2'd2
	} vcce_cfg_index_t;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'd0,
		PH_ZERO   = 3'd1,
		PH_ONE    = 3'd2,
		PH_DID    = 3'd3,
		PH_SDID   = 3'd4,
		PH_DC     = 3'd5,
		PH_USER   = 3'd6
	} vcce_phase_t;

	typedef struct packed {
		logic [9:0] caption_did;
		logic [9:0] caption_sdid;
		logic [1:0] wanted_type;
	} vcce_cfg_t;

	typedef struct packed {
		logic        result_kind;
		logic [4:0]  cc_index;
		logic        cc_valid;
		logic [1:0]  cc_type;
		logic [7:0]  cc_byte_one;
		logic [7:0]  cc_byte_two;
		logic [3:0]  frame_rate;
		logic [7:0]  cdp_flags;
		logic [15:0] sequence_count;
		logic [7:0]  footer_id;
		logic        first_of_wanted;
		logic        packet_last;
	} vcce_result_t;

endpackage

>>> design/vcce_parser.sv
// ----------------------------------------------------------------------------
// Caption packet parser
// Flag/DID/SDID search, data count capture and per-byte CDP decoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vcce_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [9:0]              word,
	input  logic                    line_end,
	input  vcce_pkg::vcce_cfg_t     cfg,
	output logic                    res_has,
	output vcce_pkg::vcce_result_t  res
);

	vcce_pkg::vcce_phase_t phase_q, phase_d, restart;
	logic [7:0]  dc_q, dc_d;
	logic [7:0]  idx_q, idx_d;
	logic [3:0]  fr_q, fr_d;
	logic [7:0]  flags_q, flags_d;
	logic [15:0] seq_q, seq_d;
	logic [4:0]  tcount_q, tcount_d;
	logic [15:0] thold_q, thold_d;
	logic [15:0] fhold_q, fhold_d;
	logic        seen_q, seen_d;
	// Position within the current triplet and triplet number, kept as counters.
	logic [1:0]  tpos_q, tpos_d;
	logic [4:0]  tnum_q, tnum_d;

	logic [7:0]  ubyte;
	logic [1:0]  ttype;
	logic        tfirst;
	logic        trip_window;

	assign ubyte = word[7:0];
	assign restart = (word == vcce_pkg::FLAG_ZERO_WORD) ? vcce_pkg::PH_ZERO
		: vcce_pkg::PH_SEARCH;
	assign trip_window = ({1'b0, idx_q} + 9'd4) < {1'b0, dc_q};
	assign ttype = thold_q[9:8];
	assign tfirst = (ttype == cfg.wanted_type) && !seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= vcce_pkg::PH_SEARCH;
			dc_q     <= '0;
			idx_q    <= '0;
			fr_q     <= '0;
			flags_q  <= '0;
			seq_q    <= '0;
			tcount_q <= '0;
			thold_q  <= '0;
			fhold_q  <= '0;
			seen_q   <= 1'b0;
			tpos_q   <= '0;
			tnum_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			dc_q     <= dc_d;
			idx_q    <= idx_d;
			fr_q     <= fr_d;
			flags_q  <= flags_d;
			seq_q    <= seq_d;
			tcount_q <= tcount_d;
			thold_q  <= thold_d;
			fhold_q  <= fhold_d;
			seen_q   <= seen_d;
			tpos_q   <= tpos_d;
			tnum_q   <= tnum_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		dc_d     = dc_q;
		idx_d    = idx_q;
		fr_d     = fr_q;
		flags_d  = flags_q;
		seq_d    = seq_q;
		tcount_d = tcount_q;
		thold_d  = thold_q;
		fhold_d  = fhold_q;
		seen_d   = seen_q;
		tpos_d   = tpos_q;
		tnum_d   = tnum_q;
		res_has  = 1'b0;
		res      = '0;

		unique case (phase_q)
			vcce_pkg::PH_ZERO: begin
				phase_d = (word == vcce_pkg::FLAG_ONE_WORD) ? vcce_pkg::PH_ONE : restart;
			end
			vcce_pkg::PH_ONE: begin
				phase_d = (word == vcce_pkg::FLAG_ONE_WORD) ? vcce_pkg::PH_DID : restart;
			end
			vcce_pkg::PH_DID: begin
				phase_d = (word == cfg.caption_did) ? vcce_pkg::PH_SDID : restart;
			end
			vcce_pkg::PH_SDID: begin
				phase_d = (word == cfg.caption_sdid) ? vcce_pkg::PH_DC : restart;
			end
			vcce_pkg::PH_DC: begin
				dc_d     = ubyte;
				idx_d    = '0;
				fr_d     = '0;
				flags_d  = '0;
				seq_d    = '0;
				tcount_d = '0;
				thold_d  = '0;
				fhold_d  = '0;
				seen_d   = 1'b0;
				tpos_d   = '0;
				tnum_d   = '0;
				phase_d  = (ubyte != 8'd0) ? vcce_pkg::PH_USER : vcce_pkg::PH_SEARCH;
			end
			vcce_pkg::PH_USER: begin
				unique case (idx_q)
					8'd3: fr_d = ubyte[7:4];
					8'd4: flags_d = ubyte;
					8'd5: seq_d = {ubyte, seq_q[7:0]};
					8'd6: seq_d = {seq_q[15:8], ubyte};
					8'd8: tcount_d = ubyte[4:0];
					default: ;
				endcase

				if (idx_q >= 8'd9) begin
					// The triplet number saturates; a saturated number never
					// passes the triplet count compare.
					if (tpos_q == 2'd2) begin
						tpos_d = 2'd0;
						if (tnum_q != 5'd31) begin
							tnum_d = tnum_q + 5'd1;
						end
					end else begin
						tpos_d = tpos_q + 2'd1;
					end

					if (trip_window && (tnum_q < tcount_q)) begin
						unique case (tpos_q)
							2'd0: thold_d = {ubyte, 8'h00};
							2'd1: thold_d = {thold_q[15:8], ubyte};
							default: begin
								seen_d = seen_q | tfirst;
								res_has = 1'b1;
								res.cc_index = tnum_q;
								res.cc_valid = thold_q[10];
								res.cc_type = ttype;
								res.cc_byte_one = thold_q[7:0];
								res.cc_byte_two = ubyte;
								res.sequence_count = seq_q;
								res.first_of_wanted = tfirst;
							end
						endcase
					end
				end

				if (dc_q >= 8'd4) begin
					if (idx_q == dc_q - 8'd4) begin
						fhold_d = {ubyte, 8'h00};
					end else if (idx_q == dc_q - 8'd3) begin
						fhold_d = {fhold_q[15:8], ubyte};
					end else if (idx_q == dc_q - 8'd2) begin
						res_has = 1'b1;
						res.result_kind = 1'b1;
						res.sequence_count = {fhold_q[7:0], ubyte};
						res.footer_id = fhold_q[15:8];
						res.packet_last = 1'b1;
					end
				end

				idx_d = idx_q + 8'd1;
				if (idx_d >= dc_q) begin
					phase_d = vcce_pkg::PH_SEARCH;
				end
			end
			default: begin
				phase_d = restart;
			end
		endcase

		if (line_end) begin
			phase_d = vcce_pkg::PH_SEARCH;
		end

		// Header fields on a result reflect this byte's update.
		res.frame_rate = fr_d;
		res.cdp_flags = flags_d;
	end

endmodule

>>> design/vanc_cdp_caption_extractor.sv
// ----------------------------------------------------------------------------
// VANC caption distribution packet extractor
// Finds caption packets in a stream of ancillary words and emits cc triplets
// and packet footers.
// ----------------------------------------------------------------------------
// One ancillary word is taken per clock while the input is not stalled. A word
// goes into an input register and is decoded in the following cycle against
// the parser state; when the word advances, any triplet or footer result
// lands in the output register behind the input register. The input stalls
// only when the word held in the input register produces a result while the
// output register is full and stalled; words that produce no result keep
// flowing. Configuration writes are always ready.
`timescale 1ns / 1ps
`include "vanc_cdp_caption_extractor_defines.svh"

module vanc_cdp_caption_extractor (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [9:0]  anc_word,
	input  logic        line_end,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [4:0]  cc_index,
	output logic        cc_valid,
	output logic [1:0]  cc_type,
	output logic [7:0]  cc_byte_one,
	output logic [7:0]  cc_byte_two,
	output logic [3:0]  frame_rate,
	output logic [7:0]  cdp_flags,
	output logic [15:0] sequence_count,
	output logic [7:0]  footer_id,
	output logic        first_of_wanted,
	output logic        packet_last
);

	vcce_pkg::vcce_cfg_t    cfg_q;
	logic                   valid_s1;
	logic [9:0]             word_s1;
	logic                   line_end_s1;
	logic                   advance;
	logic                   res_has;
	vcce_pkg::vcce_result_t res;
	logic                   out_valid_q;
	vcce_pkg::vcce_result_t out_q;
	logic                   in_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.caption_did  <= vcce_pkg::DID_RESET;
			cfg_q.caption_sdid <= vcce_pkg::SDID_RESET;
			cfg_q.wanted_type  <= vcce_pkg::WANTED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vcce_pkg::CFG_DID:    cfg_q.caption_did <= cfg_data;
				vcce_pkg::CFG_SDID:   cfg_q.caption_sdid <= cfg_data;
				vcce_pkg::CFG_WANTED: cfg_q.wanted_type <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// The held word moves on unless its result has nowhere to go.
	assign advance = valid_s1 && (!res_has || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1     <= anc_word;
			line_end_s1 <= line_end;
		end
	end

	vcce_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.word     (word_s1),
		.line_end (line_end_s1),
		.cfg      (cfg_q),
		.res_has  (res_has),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_has) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_has) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = out_q.result_kind;
	assign cc_index        = out_q.cc_index;
	assign cc_valid        = out_q.cc_valid;
	assign cc_type         = out_q.cc_type;
	assign cc_byte_one     = out_q.cc_byte_one;
	assign cc_byte_two     = out_q.cc_byte_two;
	assign frame_rate      = out_q.frame_rate;
	assign cdp_flags       = out_q.cdp_flags;
	assign sequence_count  = out_q.sequence_count;
	assign footer_id       = out_q.footer_id;
	assign first_of_wanted = out_q.first_of_wanted;
	assign packet_last     = out_q.packet_last;

	// A pending result must never overwrite a result that is still stalled.
	`VCCE_ASSERT_NOW(a_no_overwrite, valid_s1 && res_has && out_valid_q && out_stall, in_stall && !advance, "result would overwrite a stalled result")

	// A footer result carries no triplet content.
	`VCCE_ASSERT_NOW(a_footer_clean, out_valid_q && result_kind, packet_last && (cc_index == 5'd0) && !first_of_wanted && (cc_byte_one == 8'd0), "footer result carries triplet fields")

	// A transferred word is held in the input register in the next cycle.
	`VCCE_ASSERT_NEXT(a_word_held, in_valid && !in_stall, valid_s1, "transferred word was not captured")

	// A result that is stalled stays presented.
	`VCCE_ASSERT_NEXT(a_result_kept, out_valid_q && out_stall, out_valid_q, "stalled result was dropped")

endmodule

>>> dv/vcce_cdp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Caption extractor result checker
// Watches the configuration, word and result channels of the caption packet
// extractor. It tracks the packet parser on every accepted word, queues the
// triplet and footer results that the word should produce, and compares each
// accepted result field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module vcce_cdp_checker (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,

	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [9:0]  anc_word,
	input  logic        line_end,

	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        result_kind,
	input  logic [4:0]  cc_index,
	input  logic        cc_valid,
	input  logic [1:0]  cc_type,
	input  logic [7:0]  cc_byte_one,
	input  logic [7:0]  cc_byte_two,
	input  logic [3:0]  frame_rate,
	input  logic [7:0]  cdp_flags,
	input  logic [15:0] sequence_count,
	input  logic [7:0]  footer_id,
	input  logic        first_of_wanted,
	input  logic        packet_last,

	output int          fail_total,
	output int          pending_total,
	output int          checked_total,
	output int          footer_total
);
	import vcce_pkg::*;

	localparam logic KIND_TRIPLET = 1'b0;
	localparam logic KIND_FOOTER = 1'b1;

	// Byte positions within the user data of a packet.
	localparam int BYTE_RATE = 3;
	localparam int BYTE_FLAGS = 4;
	localparam int BYTE_SEQ_HI = 5;
	localparam int BYTE_SEQ_LO = 6;
	localparam int BYTE_TRIPLET_TOTAL = 8;
	localparam int BYTE_FIRST_CC = 9;
	// The footer id sits this many bytes before the end of the user data.
	localparam int FOOTER_SPAN = 4;

	logic [9:0] did_cfg;
	logic [9:0] sdid_cfg;
	logic [1:0] wanted_cfg;

	vcce_phase_t phase;
	logic [7:0]  data_count;
	logic [7:0]  user_index;
	logic [3:0]  hdr_rate;
	logic [7:0]  hdr_flags;
	logic [15:0] hdr_seq;
	logic [4:0]  cc_total;
	logic [15:0] triplet_hold;
	logic [15:0] footer_hold;
	logic        wanted_seen;

	vcce_result_t cdp_result_q[$];
	int fail_count;
	int checked_count;
	int footer_count;

	task automatic note_failure(input string msg);
		fail_count++;
		$display("%0t ns mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			note_failure($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
				checked_count, name, got, want));
	endtask

	function automatic vcce_phase_t restart_phase(input logic [9:0] w);
		return (w == FLAG_ZERO_WORD) ? PH_ZERO : PH_SEARCH;
	endfunction

	task automatic clear_packet();
		hdr_rate = '0;
		hdr_flags = '0;
		hdr_seq = '0;
		cc_total = '0;
		triplet_hold = '0;
		footer_hold = '0;
		wanted_seen = 1'b0;
	endtask

	task automatic take_user_byte(input logic [7:0] b);
		int idx;
		int count;
		int slot;
		vcce_result_t r;
		idx = user_index;
		count = data_count;
		slot = idx - BYTE_FIRST_CC;
		r = '0;
		case (idx)
			BYTE_RATE: hdr_rate = b[7:4];
			BYTE_FLAGS: hdr_flags = b;
			BYTE_SEQ_HI: hdr_seq[15:8] = b;
			BYTE_SEQ_LO: hdr_seq[7:0] = b;
			BYTE_TRIPLET_TOTAL: cc_total = b[4:0];
			default: ;
		endcase
		// Results carry the header as it stands after this byte.
		r.frame_rate = hdr_rate;
		r.cdp_flags = hdr_flags;
		// Triplet bytes are only taken ahead of the footer, so a triplet still
		// open when the footer starts never produces a result.
		if (idx >= BYTE_FIRST_CC && idx + FOOTER_SPAN < count && slot / 3 < cc_total) begin
			case (slot % 3)
				0: triplet_hold = {b, 8'h00};
				1: triplet_hold[7:0] = b;
				default: begin
					r.result_kind = KIND_TRIPLET;
					r.cc_index = 5'(slot / 3);
					r.cc_valid = triplet_hold[10];
					r.cc_type = triplet_hold[9:8];
					r.cc_byte_one = triplet_hold[7:0];
					r.cc_byte_two = b;
					r.sequence_count = hdr_seq;
					if (triplet_hold[9:8] == wanted_cfg && !wanted_seen) begin
						r.first_of_wanted = 1'b1;
						wanted_seen = 1'b1;
					end
					cdp_result_q.push_back(r);
				end
			endcase
		end
		if (count >= FOOTER_SPAN) begin
			if (idx == count - FOOTER_SPAN) begin
				footer_hold = {b, 8'h00};
			end else if (idx == count - FOOTER_SPAN + 1) begin
				footer_hold[7:0] = b;
			end else if (idx == count - FOOTER_SPAN + 2) begin
				r.result_kind = KIND_FOOTER;
				r.sequence_count = {footer_hold[7:0], b};
				r.footer_id = footer_hold[15:8];
				r.packet_last = 1'b1;
				cdp_result_q.push_back(r);
			end
		end
	endtask

	task automatic parse_anc_word(input logic [9:0] w, input logic le);
		case (phase)
			PH_ZERO: phase = (w == FLAG_ONE_WORD) ? PH_ONE : restart_phase(w);
			PH_ONE: phase = (w == FLAG_ONE_WORD) ? PH_DID : restart_phase(w);
			PH_DID: phase = (w == did_cfg) ? PH_SDID : restart_phase(w);
			PH_SDID: phase = (w == sdid_cfg) ? PH_DC : restart_phase(w);
			PH_DC: begin
				data_count = w[7:0];
				user_index = '0;
				clear_packet();
				phase = (w[7:0] != 8'd0) ? PH_USER : PH_SEARCH;
			end
			PH_USER: begin
				take_user_byte(w[7:0]);
				user_index = user_index + 8'd1;
				if (user_index >= data_count)
					phase = PH_SEARCH;
			end
			default: phase = restart_phase(w);
		endcase
		if (le)
			phase = PH_SEARCH;
	endtask

	task automatic compare_result();
		vcce_result_t want;
		if (cdp_result_q.size() == 0) begin
			note_failure($sformatf("result of kind %0d with nothing outstanding", result_kind));
			return;
		end
		want = cdp_result_q.pop_front();
		checked_count++;
		if (want.result_kind == KIND_FOOTER)
			footer_count++;
		check_field("result_kind", 16'(result_kind), 16'(want.result_kind));
		check_field("cc_index", 16'(cc_index), 16'(want.cc_index));
		check_field("cc_valid", 16'(cc_valid), 16'(want.cc_valid));
		check_field("cc_type", 16'(cc_type), 16'(want.cc_type));
		check_field("cc_byte_one", 16'(cc_byte_one), 16'(want.cc_byte_one));
		check_field("cc_byte_two", 16'(cc_byte_two), 16'(want.cc_byte_two));
		check_field("frame_rate", 16'(frame_rate), 16'(want.frame_rate));
		check_field("cdp_flags", 16'(cdp_flags), 16'(want.cdp_flags));
		check_field("sequence_count", sequence_count, want.sequence_count);
		check_field("footer_id", 16'(footer_id), 16'(want.footer_id));
		check_field("first_of_wanted", 16'(first_of_wanted), 16'(want.first_of_wanted));
		check_field("packet_last", 16'(packet_last), 16'(want.packet_last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			did_cfg = DID_RESET;
			sdid_cfg = SDID_RESET;
			wanted_cfg = WANTED_RESET;
			phase = PH_SEARCH;
			data_count = '0;
			user_index = '0;
			clear_packet();
			cdp_result_q.delete();
			fail_count = 0;
			checked_count = 0;
			footer_count = 0;
		end else begin
			if (out_valid && !out_stall)
				compare_result();
			if (cfg_valid && cfg_ready) begin
				case (vcce_cfg_index_t'(cfg_index))
					CFG_DID: did_cfg = cfg_data;
					CFG_SDID: sdid_cfg = cfg_data;
					CFG_WANTED: wanted_cfg = cfg_data[1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				parse_anc_word(anc_word, line_end);
		end
		fail_total <= fail_count;
		pending_total <= cdp_result_q.size();
		checked_total <= checked_count;
		footer_total <= footer_count;
	end

endmodule

>>> dv/tb_vanc_cdp_caption_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Caption extractor testbench
// Feeds the caption packet extractor with streams of ancillary words: well
// formed caption packets with random content, damaged flags and identifiers,
// packets cut by a line end, and noise. Register settings change between
// phases, both sides idle at random, and the checker beside the block
// compares every result it produces.
// ----------------------------------------------------------------------------
module tb_vanc_cdp_caption_extractor;
	import vcce_pkg::*;

	localparam int PHASE_WORDS = 80;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 8;
	localparam int BYTE_TRIPLET_TOTAL = 8;

	typedef enum int {
		PK_GOOD,
		PK_BAD_FLAG,
		PK_BAD_DID,
		PK_BAD_SDID,
		PK_CUT,
		PK_NOISE
	} packet_shape_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [9:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [9:0]  anc_word;
	logic        line_end;
	logic        out_valid;
	logic        out_stall;
	logic        result_kind;
	logic [4:0]  cc_index;
	logic        cc_valid;
	logic [1:0]  cc_type;
	logic [7:0]  cc_byte_one;
	logic [7:0]  cc_byte_two;
	logic [3:0]  frame_rate;
	logic [7:0]  cdp_flags;
	logic [15:0] sequence_count;
	logic [7:0]  footer_id;
	logic        first_of_wanted;
	logic        packet_last;

	int fail_total;
	int pending_total;
	int checked_total;
	int footer_total;

	logic [9:0] cur_did;
	logic [9:0] cur_sdid;
	logic [9:0] word_q[$];
	logic       end_q[$];
	int words_sent;
	int packets_built;
	int settings_applied;
	int hold_requests;
	bit sender_gaps;
	bit quiet_tail;

	vanc_cdp_caption_extractor DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.anc_word        (anc_word),
		.line_end        (line_end),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_kind     (result_kind),
		.cc_index        (cc_index),
		.cc_valid        (cc_valid),
		.cc_type         (cc_type),
		.cc_byte_one     (cc_byte_one),
		.cc_byte_two     (cc_byte_two),
		.frame_rate      (frame_rate),
		.cdp_flags       (cdp_flags),
		.sequence_count  (sequence_count),
		.footer_id       (footer_id),
		.first_of_wanted (first_of_wanted),
		.packet_last     (packet_last)
	);

	vcce_cdp_checker cdp_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog for a hung handshake or a result that never arrives.
	initial begin
		#3_000_000;
		$display("vanc_cdp_caption_extractor regression: fail");
		$finish;
	end

	// Result side: short random stalls, plus one long hold on request so the
	// block backs up and stalls its word input.
	initial begin
		int holds_served;
		holds_served = 0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic push_word(input logic [9:0] w, input logic le);
		word_q.push_back(w);
		end_q.push_back(le);
	endtask

	task automatic send_word(input logic [9:0] w, input logic le);
		if (sender_gaps && !quiet_tail && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		anc_word <= w;
		line_end <= le;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic flush_words();
		while (word_q.size() != 0)
			send_word(word_q.pop_front(), end_q.pop_front());
	endtask

	task automatic build_packet(input packet_shape_t shape, input int dc, input int cc,
			input bit pattern);
		logic [9:0] flag_w[3];
		logic [7:0] ub;
		int cut_at;
		int i;
		packets_built++;
		if (shape == PK_NOISE) begin
			repeat ($urandom_range(3, 12))
				push_word(($urandom_range(0, 3) == 0) ? FLAG_ZERO_WORD : 10'($urandom),
					$urandom_range(0, 15) == 0);
			return;
		end
		flag_w[0] = FLAG_ZERO_WORD;
		flag_w[1] = FLAG_ONE_WORD;
		flag_w[2] = FLAG_ONE_WORD;
		if (shape == PK_BAD_FLAG)
			flag_w[$urandom_range(0, 2)] = 10'($urandom);
		if (!pattern && $urandom_range(0, 4) == 0)
			push_word(FLAG_ZERO_WORD, 1'b0);
		for (i = 0; i < 3; i++)
			push_word(flag_w[i], 1'b0);
		if (shape == PK_BAD_DID && $urandom_range(0, 1) == 1) begin
			// A zero word where the DID belongs opens a fresh flag that the
			// packet then follows.
			push_word(FLAG_ZERO_WORD, 1'b0);
			push_word(FLAG_ONE_WORD, 1'b0);
			push_word(FLAG_ONE_WORD, 1'b0);
			push_word(cur_did, 1'b0);
		end else if (shape == PK_BAD_DID) begin
			push_word(cur_did ^ 10'($urandom_range(1, 1023)), 1'b0);
		end else begin
			push_word(cur_did, 1'b0);
		end
		push_word((shape == PK_BAD_SDID) ? cur_sdid ^ 10'($urandom_range(1, 1023)) : cur_sdid,
			1'b0);
		cut_at = (shape == PK_CUT) ? $urandom_range(0, dc) : -1;
		push_word({pattern ? 2'b00 : 2'($urandom), 8'(dc)}, cut_at == dc);
		for (i = 0; i < dc; i++) begin
			ub = pattern ? ((i % 2 == 1) ? 8'hFF : 8'h00) : 8'($urandom);
			if (i == BYTE_TRIPLET_TOTAL)
				ub = {pattern ? 3'b111 : 3'($urandom), 5'(cc)};
			push_word({pattern ? ub[1:0] : 2'($urandom), ub}, i == cut_at);
		end
		// Checksum word, which the parser only sees as a searched word.
		push_word(10'($urandom), pattern ? 1'b1 : ($urandom_range(0, 2) == 0));
	endtask

	function automatic packet_shape_t pick_shape();
		int r;
		r = $urandom_range(0, 99);
		if (r < 58) return PK_GOOD;
		if (r < 66) return PK_BAD_FLAG;
		if (r < 74) return PK_BAD_DID;
		if (r < 80) return PK_BAD_SDID;
		if (r < 88) return PK_CUT;
		return PK_NOISE;
	endfunction

	task automatic build_random_packet();
		int sel;
		int dc;
		int cc;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			dc = $urandom_range(200, 255);
		else if (sel < 4)
			dc = $urandom_range(0, 5);
		else
			dc = $urandom_range(6, 48);
		// Mostly the largest triplet count that fits in the space ahead of the footer.
		cc = (dc > 13) ? (dc - 13) / 3 : 0;
		if (cc > 31)
			cc = 31;
		if ($urandom_range(0, 3) == 0)
			cc = $urandom_range(0, 31);
		build_packet(pick_shape(), dc, cc, 1'b0);
	endtask

	task automatic write_reg(input vcce_cfg_index_t idx, input logic [9:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic program_regs(input logic [9:0] did, input logic [9:0] sdid,
			input logic [9:0] wanted);
		write_reg(CFG_DID, did);
		write_reg(CFG_SDID, sdid);
		write_reg(CFG_WANTED, wanted);
		cfg_valid <= 1'b0;
		cur_did = did;
		cur_sdid = sdid;
		settings_applied++;
	endtask

	// Let every outstanding result drain, then give the last words time to
	// pass through the pipeline even if they produce nothing.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_total != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [9:0] did, input logic [9:0] sdid,
			input logic [9:0] wanted, input bit gaps, input bit pressure);
		int start;
		settle();
		program_regs(did, sdid, wanted);
		sender_gaps = gaps;
		start = words_sent;
		if (pressure) begin
			hold_requests <= hold_requests + 1;
			build_packet(PK_GOOD, 110, 31, 1'b0);
			flush_words();
		end
		while (words_sent - start < PHASE_WORDS) begin
			build_random_packet();
			flush_words();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DID;
		cfg_data = '0;
		in_valid = 1'b0;
		anc_word = '0;
		line_end = 1'b0;
		cur_did = DID_RESET;
		cur_sdid = SDID_RESET;
		words_sent = 0;
		packets_built = 0;
		settings_applied = 0;
		hold_requests = 0;
		sender_gaps = 1'b0;
		quiet_tail = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one packet of all-zero and all-one bytes ending on a
		// line end, then a packet with a zero data count.
		build_packet(PK_GOOD, 16, 1, 1'b1);
		build_packet(PK_GOOD, 0, 0, 1'b1);
		flush_words();

		run_phase(DID_RESET, SDID_RESET, 10'h003, 1'b1, 1'b0);
		run_phase(10'h000, 10'h3FF, 10'h000, 1'b1, 1'b0);
		run_phase(10'h3FF, 10'h000, 10'h3FD, 1'b0, 1'b0);
		run_phase(10'($urandom), 10'($urandom), 10'h002, 1'b1, 1'b0);
		run_phase(DID_RESET, SDID_RESET, 10'($urandom), 1'b1, 1'b1);
		quiet_tail <= 1'b1;
		run_phase(DID_RESET, SDID_RESET, 10'(WANTED_RESET), 1'b0, 1'b0);
		settle();

		$display("Covered %0d ancillary words in %0d packets and noise runs under %0d settings.",
			words_sent, packets_built, settings_applied + 1);
		$display("Compared %0d results, %0d of them packet footers; %0d mismatches.",
			checked_total, footer_total, fail_total);
		if (fail_total == 0)
			$display("vanc_cdp_caption_extractor regression: pass");
		else
			$display("vanc_cdp_caption_extractor regression: fail");
		$finish;
	end

endmodule
